@@ hw/rtl/time_slot_resource_reserver_assert.svh @@
// Assertion macros used by the checker of this block.
`ifndef TIME_SLOT_RESOURCE_RESERVER_ASSERT_SVH
`define TIME_SLOT_RESOURCE_RESERVER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TSR_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TSR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/tsr_pkg.sv @@
package tsr_pkg;

    localparam int DEF_NUM_SLOTS     = 24 * 4;
    localparam int DEF_NUM_RESOURCES = 16;

    localparam int CMD_W    = 2;
    localparam int RES_W    = 4;
    localparam int SLOT_W   = 7;
    localparam int STATUS_W = 2;
    localparam int GRANT_W  = 4;
    localparam int MASK_W   = 16;

    typedef enum logic [CMD_W-1:0] {
        CMD_RESERVE = 2'd0,
        CMD_RELEASE = 2'd1,
        CMD_CHECK   = 2'd2,
        CMD_REPORT  = 2'd3
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FAIL  = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    typedef struct packed {
        logic clr_we;
        logic load;
        logic idx_clr;
        logic step;
        logic wr_pass;
        logic decide;
    } t_ctl;

    typedef struct packed {
        logic clr_last;
        logic skip;
        logic pass_last;
        logic do_write;
    } t_sts;

endpackage

@@ hw/rtl/time_slot_resource_reserver.sv @@
// A command whose window is out of range or empty skips the slot memory; any other command
// reads each slot of its window in one pass, and one that writes back makes a second pass.
// A new word is taken at the edge that takes the result, so the block works on one command
// at a time; each pass reads the slot memory once per slot.
// After reset the block is busy while it marks every resource free.
// The receiver cannot stall: each result is shown for exactly one cycle.
module time_slot_resource_reserver #(
    parameter int NUM_SLOTS     = tsr_pkg::DEF_NUM_SLOTS,
    parameter int NUM_RESOURCES = tsr_pkg::DEF_NUM_RESOURCES
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [tsr_pkg::CMD_W-1:0]    i_command,
    input  logic [tsr_pkg::RES_W-1:0]    i_resource,
    input  logic [tsr_pkg::SLOT_W-1:0]   i_start_slot,
    input  logic [tsr_pkg::SLOT_W-1:0]   i_span,
    output logic                         o_done,
    output logic [tsr_pkg::STATUS_W-1:0] o_status,
    output logic [tsr_pkg::GRANT_W-1:0]  o_granted,
    output logic [tsr_pkg::MASK_W-1:0]   o_free_mask
);

    tsr_pkg::t_ctl ctl;
    tsr_pkg::t_sts sts;

    tsr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_ctl   (ctl),
        .o_busy  (busy),
        .o_done  (o_done)
    );

    tsr_datapath #(
        .NUM_SLOTS     (NUM_SLOTS),
        .NUM_RESOURCES (NUM_RESOURCES)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (ctl),
        .i_command    (i_command),
        .i_resource   (i_resource),
        .i_start_slot (i_start_slot),
        .i_span       (i_span),
        .o_sts        (sts),
        .o_status     (o_status),
        .o_granted    (o_granted),
        .o_free_mask  (o_free_mask)
    );

endmodule

@@ hw/rtl/tsr_ram.sv @@
module tsr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 96
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/tsr_ctrl.sv @@
module tsr_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  tsr_pkg::t_sts i_sts,
    output tsr_pkg::t_ctl o_ctl,
    output logic          o_busy,
    output logic          o_done
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_EVAL,
        S_READ,
        S_RTAIL,
        S_DECIDE,
        S_WRITE,
        S_WTAIL,
        S_RESP
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_busy;
    logic   r_done;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                n_state = i_sts.skip ? S_DECIDE : S_READ;
            end
            S_READ: begin
                if (i_sts.pass_last) begin
                    n_state = S_RTAIL;
                end
            end
            S_RTAIL: begin
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                n_state = S_WRITE;
            end
            S_WRITE: begin
                if (!i_sts.do_write) begin
                    n_state = S_RESP;
                end else if (i_sts.pass_last) begin
                    n_state = S_WTAIL;
                end
            end
            S_WTAIL: begin
                n_state = S_RESP;
            end
            S_RESP: begin
                n_state = i_start ? S_EVAL : S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_ctl         = '0;
        o_ctl.clr_we  = (r_state == S_CLEAR);
        o_ctl.load    = ((r_state == S_IDLE) || (r_state == S_RESP)) && i_start;
        o_ctl.idx_clr = (r_state == S_DECIDE);
        o_ctl.decide  = (r_state == S_DECIDE);
        o_ctl.step    = (r_state == S_READ) || ((r_state == S_WRITE) && i_sts.do_write);
        o_ctl.wr_pass = (r_state == S_WRITE) || (r_state == S_WTAIL);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_busy  <= 1'b1;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= (n_state != S_IDLE) && (n_state != S_RESP);
            r_done  <= (n_state == S_RESP);
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;

endmodule

@@ hw/rtl/tsr_datapath.sv @@
module tsr_datapath #(
    parameter int NUM_SLOTS     = tsr_pkg::DEF_NUM_SLOTS,
    parameter int NUM_RESOURCES = tsr_pkg::DEF_NUM_RESOURCES
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  tsr_pkg::t_ctl                i_ctl,
    input  logic [tsr_pkg::CMD_W-1:0]    i_command,
    input  logic [tsr_pkg::RES_W-1:0]    i_resource,
    input  logic [tsr_pkg::SLOT_W-1:0]   i_start_slot,
    input  logic [tsr_pkg::SLOT_W-1:0]   i_span,
    output tsr_pkg::t_sts                o_sts,
    output logic [tsr_pkg::STATUS_W-1:0] o_status,
    output logic [tsr_pkg::GRANT_W-1:0]  o_granted,
    output logic [tsr_pkg::MASK_W-1:0]   o_free_mask
);

    localparam int AW   = $clog2(NUM_SLOTS);
    localparam int RW   = $clog2(NUM_RESOURCES);
    localparam int SUMW = ((AW > tsr_pkg::SLOT_W + 1) ? AW : tsr_pkg::SLOT_W + 1) + 1;

    tsr_pkg::t_cmd             r_cmd;
    logic [tsr_pkg::RES_W-1:0]  r_res;
    logic [tsr_pkg::SLOT_W-1:0] r_first;
    logic [tsr_pkg::SLOT_W-1:0] r_count;
    logic [tsr_pkg::SLOT_W-1:0] r_idx;
    logic [AW-1:0]              r_clr_addr;
    logic                       r_vld;
    logic [AW-1:0]              r_wa;
    logic [NUM_RESOURCES-1:0]   r_acc_and;
    logic [NUM_RESOURCES-1:0]   r_acc_or;
    logic [NUM_RESOURCES-1:0]   r_bit;
    logic                       r_set;
    logic                       r_do_write;
    tsr_pkg::t_status           r_status;
    logic [tsr_pkg::GRANT_W-1:0] r_granted;
    logic [tsr_pkg::MASK_W-1:0]  r_mask;

    tsr_pkg::t_status            n_status;
    logic [tsr_pkg::GRANT_W-1:0] n_granted;
    logic [tsr_pkg::MASK_W-1:0]  n_mask;
    logic                        n_do_write;
    logic [RW-1:0]               n_bit_idx;

    logic [AW-1:0]            rd_addr;
    logic [NUM_RESOURCES-1:0] rdata;
    logic                     ram_we;
    logic [AW-1:0]            ram_waddr;
    logic [NUM_RESOURCES-1:0] ram_wdata;
    logic                     range_err;
    logic                     span_zero;
    logic                     res_ok;
    logic [RW-1:0]            res_idx;
    logic [NUM_RESOURCES-1:0] avail;
    logic [RW-1:0]            pick;

    assign rd_addr   = AW'(SUMW'(r_first) + SUMW'(r_idx));
    assign ram_we    = i_ctl.clr_we || (r_vld && i_ctl.wr_pass);
    assign ram_waddr = i_ctl.clr_we ? r_clr_addr : r_wa;
    assign ram_wdata = i_ctl.clr_we ? '1 : (r_set ? (rdata | r_bit) : (rdata & ~r_bit));

    tsr_ram #(
        .WIDTH (NUM_RESOURCES),
        .DEPTH (NUM_SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (rd_addr),
        .o_rdata (rdata)
    );

    assign range_err = (SUMW'(r_first) >= SUMW'(NUM_SLOTS))
                    || ((SUMW'(r_first) + SUMW'(r_count)) > SUMW'(NUM_SLOTS));
    assign span_zero = (r_count == '0);
    assign res_ok    = (32'(r_res) < NUM_RESOURCES);
    assign res_idx   = RW'(r_res);
    assign avail     = span_zero ? '0 : r_acc_and;

    always_comb begin
        pick = '0;
        for (int i = NUM_RESOURCES - 1; i >= 0; i--) begin
            if (avail[i]) begin
                pick = RW'(i);
            end
        end
    end

    always_comb begin
        n_status   = tsr_pkg::ST_OK;
        n_granted  = '0;
        n_mask     = tsr_pkg::MASK_W'(avail);
        n_do_write = 1'b0;
        n_bit_idx  = res_idx;
        if (range_err) begin
            n_status = tsr_pkg::ST_RANGE;
            n_mask   = '0;
        end else begin
            unique case (r_cmd)
                tsr_pkg::CMD_RESERVE: begin
                    n_bit_idx = pick;
                    if (avail == '0) begin
                        n_status = tsr_pkg::ST_FAIL;
                    end else begin
                        n_granted  = tsr_pkg::GRANT_W'(pick);
                        n_do_write = 1'b1;
                    end
                end
                tsr_pkg::CMD_RELEASE: begin
                    if (!res_ok || r_acc_or[res_idx]) begin
                        n_status = tsr_pkg::ST_FAIL;
                    end else begin
                        n_granted  = r_res;
                        n_do_write = !span_zero;
                    end
                end
                tsr_pkg::CMD_CHECK: begin
                    if (!res_ok || !r_acc_and[res_idx]) begin
                        n_status = tsr_pkg::ST_FAIL;
                    end else begin
                        n_granted = r_res;
                    end
                end
                tsr_pkg::CMD_REPORT: begin
                    n_status = tsr_pkg::ST_OK;
                end
                default: begin
                    n_status = tsr_pkg::ST_OK;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld      <= 1'b0;
            r_clr_addr <= '0;
            r_idx      <= '0;
            r_do_write <= 1'b0;
        end else begin
            r_vld <= i_ctl.step;
            if (i_ctl.clr_we) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            if (i_ctl.load || i_ctl.idx_clr) begin
                r_idx <= '0;
            end else if (i_ctl.step) begin
                r_idx <= r_idx + tsr_pkg::SLOT_W'(1);
            end
            if (i_ctl.decide) begin
                r_do_write <= n_do_write;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_wa <= rd_addr;
        if (i_ctl.load) begin
            r_cmd     <= tsr_pkg::t_cmd'(i_command);
            r_res     <= i_resource;
            r_first   <= i_start_slot;
            r_count   <= i_span;
            r_acc_and <= '1;
            r_acc_or  <= '0;
        end else if (r_vld && !i_ctl.wr_pass) begin
            r_acc_and <= r_acc_and & rdata;
            r_acc_or  <= r_acc_or | rdata;
        end
        if (i_ctl.decide) begin
            r_status  <= n_status;
            r_granted <= n_granted;
            r_mask    <= n_mask;
            r_bit     <= NUM_RESOURCES'(1) << n_bit_idx;
            r_set     <= (r_cmd == tsr_pkg::CMD_RELEASE);
        end
    end

    assign o_sts.clr_last  = (r_clr_addr == AW'(NUM_SLOTS - 1));
    assign o_sts.skip      = range_err || span_zero;
    assign o_sts.pass_last = (r_idx == r_count - tsr_pkg::SLOT_W'(1));
    assign o_sts.do_write  = r_do_write;

    assign o_status    = r_status;
    assign o_granted   = r_granted;
    assign o_free_mask = r_mask;

endmodule

@@ hw/rtl/tsr_checker.sv @@
`include "time_slot_resource_reserver_assert.svh"

module tsr_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         start,
    input logic                         busy,
    input logic                         o_done,
    input logic [tsr_pkg::STATUS_W-1:0] o_status,
    input logic [tsr_pkg::GRANT_W-1:0]  o_granted,
    input logic [tsr_pkg::MASK_W-1:0]   o_free_mask
);

    // An accepted word keeps the block busy until its result appears.
    `TSR_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy && !o_done, "accepted word did not raise busy")
    `TSR_ASSERT_SAME(a_done_idle, i_clk, i_rst_n, o_done, !busy, "result shown while busy")
    `TSR_ASSERT_NEXT(a_done_single, i_clk, i_rst_n, o_done, !o_done, "result strobe lasted more than one cycle")
    `TSR_ASSERT_SAME(a_range_clean, i_clk, i_rst_n, o_done && (o_status == tsr_pkg::ST_RANGE), (o_granted == '0) && (o_free_mask == '0), "out-of-range result carries data")
    `TSR_ASSERT_SAME(a_fail_grant, i_clk, i_rst_n, o_done && (o_status != tsr_pkg::ST_OK), o_granted == '0, "failed result names a resource")

endmodule

bind time_slot_resource_reserver tsr_checker u_tsr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .o_done      (o_done),
    .o_status    (o_status),
    .o_granted   (o_granted),
    .o_free_mask (o_free_mask)
);
